// ----- src/mmc_pkg.sv -----
// ----------------------------------------------------------------------------
// mmc_pkg: shared definitions for the magnetometer min/max calibration block
// Widths, field codes, fixed-point settings and the request and response
// types that pass between the sequencer and the correction unit.
// ----------------------------------------------------------------------------
package mmc_pkg;

    localparam int SCALE_FRACTION_BITS  = 16;
    localparam int OUTPUT_FRACTION_BITS = 4;

    localparam int MODE_W    = 2;
    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 16;
    localparam int OFFSET_W  = SAMPLE_W + 1;
    localparam int RANGE_W   = SAMPLE_W + 1;
    localparam int SUM_W     = RANGE_W + 2;
    localparam int SCALE_W   = 24;
    localparam int OUT_W     = 24;
    localparam int STATUS_W  = 2;
    localparam int AXIS_W    = 2;
    localparam int NUM_AXES  = 3;

    localparam int DIFF_W      = SAMPLE_W + 2;
    localparam int PROD_W      = DIFF_W + SCALE_W + 1;
    localparam int ROUND_SHIFT = 1 + SCALE_FRACTION_BITS - OUTPUT_FRACTION_BITS;

    localparam int DIVIDEND_W = SUM_W + SCALE_FRACTION_BITS + 1;
    localparam int DIVISOR_W  = RANGE_W + 2;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

    localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = 16'd10;
    localparam logic [SCALE_W-1:0] SCALE_UNITY     = SCALE_W'(1) << SCALE_FRACTION_BITS;
    localparam logic [SCALE_W-1:0] SCALE_MAX       = '1;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef logic [AXIS_W-1:0] t_axis;

    typedef struct packed {
        logic                        valid;
        t_axis                       axis;
        logic                        cal_valid;
        logic signed [SAMPLE_W-1:0]  raw;
        logic signed [OFFSET_W-1:0]  offset;
        logic        [SCALE_W-1:0]   scale;
    } t_corr_req;

    typedef struct packed {
        logic                     valid;
        t_axis                    axis;
        logic signed [OUT_W-1:0]  value;
    } t_corr_rsp;

endpackage

// ----- src/mmc_divider.sv -----
// ----------------------------------------------------------------------------
// mmc_divider: radix-2 restoring divider
// Produces one quotient bit per cycle; the dividend register shifts the
// quotient in from the bottom as the dividend bits leave at the top.
// ----------------------------------------------------------------------------
module mmc_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mmc_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [mmc_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                               o_done,
    output logic [mmc_pkg::DIVIDEND_W-1:0]     o_quotient
);
    import mmc_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic [DIVIDEND_W-1:0]   r_quo;
    logic [DIVISOR_W-1:0]    r_rem;
    logic [DIVISOR_W-1:0]    r_div;

    logic [DIVISOR_W:0]      w_rem_shift;
    logic                    w_fits;
    logic [DIVISOR_W:0]      w_rem_next;

    always_comb begin
        w_rem_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        w_fits      = w_rem_shift >= {1'b0, r_div};
        w_rem_next  = w_fits ? (w_rem_shift - {1'b0, r_div}) : w_rem_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fits};
            r_rem <= w_rem_next[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- src/mmc_corrector.sv -----
// ----------------------------------------------------------------------------
// mmc_corrector: shared per-axis correction unit
// Two stages: offset removal and scale multiply, then rounding and saturation
// (or raw pass-through when uncalibrated). One axis may enter every cycle.
// ----------------------------------------------------------------------------
module mmc_corrector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mmc_pkg::t_corr_req   i_req,
    output mmc_pkg::t_corr_rsp   o_rsp
);
    import mmc_pkg::*;

    logic signed [DIFF_W-1:0]    w_diff;
    logic signed [PROD_W-1:0]    w_prod;

    logic                        r_s1_valid;
    t_axis                       r_s1_axis;
    logic                        r_s1_bypass;
    logic signed [SAMPLE_W-1:0]  r_s1_raw;
    logic signed [PROD_W-1:0]    r_s1_prod;

    logic [PROD_W-1:0]           w_mag;
    logic [PROD_W-1:0]           w_rnd;
    logic signed [OUT_W-1:0]     w_value;

    logic                        r_s2_valid;
    t_axis                       r_s2_axis;
    logic signed [OUT_W-1:0]     r_s2_value;

    always_comb begin
        w_diff = (DIFF_W'(i_req.raw) <<< 1) - DIFF_W'(i_req.offset);
        w_prod = w_diff * $signed({1'b0, i_req.scale});
    end

    always_comb begin
        w_mag = r_s1_prod[PROD_W-1] ? PROD_W'(-r_s1_prod) : PROD_W'(r_s1_prod);
        w_rnd = (w_mag + (PROD_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        if (r_s1_bypass) begin
            w_value = OUT_W'(r_s1_raw) <<< OUTPUT_FRACTION_BITS;
        end else if (!r_s1_prod[PROD_W-1]) begin
            if (w_rnd > PROD_W'((64'd1 << (OUT_W - 1)) - 64'd1)) begin
                w_value = {1'b0, {(OUT_W-1){1'b1}}};
            end else begin
                w_value = w_rnd[OUT_W-1:0];
            end
        end else begin
            if (w_rnd > PROD_W'(64'd1 << (OUT_W - 1))) begin
                w_value = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                w_value = OUT_W'(-w_rnd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_axis   <= i_req.axis;
        r_s1_bypass <= !i_req.cal_valid;
        r_s1_raw    <= i_req.raw;
        r_s1_prod   <= w_prod;
        r_s2_axis   <= r_s1_axis;
        r_s2_value  <= w_value;
    end

    always_comb begin
        o_rsp.valid = r_s2_valid;
        o_rsp.axis  = r_s2_axis;
        o_rsp.value = r_s2_value;
    end

endmodule

// ----- src/magnetometer_minmax_calibration.sv -----
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration: hard- and soft-iron min/max calibration
//
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: sample_x, sample_y, sample_z; tuser: mode
// m_axis    out  tdata: corrected_x/y/z; tuser: finish_status, calibrated_flag,
//                calibrating_flag
// apb       in   min_sample_count at byte address 0
//
// A beat goes from acceptance to its result beat through one state update,
// three passes through the shared correction multiplier and its two-stage
// pipeline, and the output load. An accepted finish adds three axis scales,
// each a run of the serial divider, or set directly when no division is needed.
// Reset is synchronous and needs no clearing pass. A stalled result beat
// holds the output register; the next beat is taken once the block is idle.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibration (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [47:0]                      s_axis_tdata,   // sample_x, sample_y, sample_z
    input  logic [1:0]                       s_axis_tuser,   // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [71:0]                      m_axis_tdata,   // corrected_x, _y, _z
    output logic [3:0]                       m_axis_tuser,   // status, calibrated, calibrating
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mmc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mmc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import mmc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_UPDATE    = 7'b0000010,
        S_DIV_SETUP = 7'b0000100,
        S_DIV_WAIT  = 7'b0001000,
        S_CORRECT   = 7'b0010000,
        S_DRAIN     = 7'b0100000,
        S_DONE      = 7'b1000000
    } t_state;

    t_state                       r_state, n_state;

    logic [COUNT_W-1:0]           r_min_count;
    logic [MODE_W-1:0]            r_mode;
    logic signed [SAMPLE_W-1:0]   r_sample [NUM_AXES];
    logic signed [SAMPLE_W-1:0]   r_min    [NUM_AXES];
    logic signed [SAMPLE_W-1:0]   r_max    [NUM_AXES];
    logic signed [OFFSET_W-1:0]   r_offset [NUM_AXES];
    logic        [SCALE_W-1:0]    r_scale  [NUM_AXES];
    logic signed [OUT_W-1:0]      r_res    [NUM_AXES];
    logic [COUNT_W-1:0]           r_count;
    logic                         r_collecting;
    logic                         r_cal_valid;
    logic [STATUS_W-1:0]          r_status;
    t_axis                        r_axis;
    logic                         r_m_valid;
    logic [71:0]                  r_m_data;
    logic [3:0]                   r_m_user;

    logic signed [RANGE_W-1:0]    w_range [NUM_AXES];
    logic signed [SUM_W-1:0]      w_sum;
    logic signed [RANGE_W-1:0]    w_range_cur;
    logic [RANGE_W-2:0]           w_range_u;
    logic [SUM_W-2:0]             w_sum_u;
    logic                         w_need_div;
    logic                         w_sum_pos;
    logic [DIVIDEND_W-1:0]        w_dividend;
    logic [DIVISOR_W-1:0]         w_divisor;
    logic                         w_div_start;
    logic                         w_div_done;
    logic [DIVIDEND_W-1:0]        w_quotient;
    logic [SCALE_W-1:0]           w_quot_sat;
    logic                         w_in_fire;
    logic                         w_out_fire;
    logic                         w_out_load;
    logic                         w_cfg_wr;
    t_corr_req                    w_req;
    t_corr_rsp                    w_rsp;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = r_m_valid && m_axis_tready;
    assign w_out_load = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);
    assign w_cfg_wr   = psel && penable && pwrite && pready && !paddr[2];

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            w_range[i] = RANGE_W'(r_max[i]) - RANGE_W'(r_min[i]);
            w_sum      = w_sum + SUM_W'(w_range[i]);
        end
        w_range_cur = w_range[r_axis];
        w_range_u   = w_range_cur[RANGE_W-2:0];
        w_sum_u     = w_sum[SUM_W-2:0];
        w_sum_pos   = !w_sum[SUM_W-1] && (w_sum != '0);
        w_need_div  = (w_range_cur > RANGE_W'(2)) && w_sum_pos;
        w_dividend  = (DIVIDEND_W'(w_sum_u) << (SCALE_FRACTION_BITS + 1))
                    + DIVIDEND_W'(w_range_u) * DIVIDEND_W'(3);
        w_divisor   = DIVISOR_W'(w_range_u) * DIVISOR_W'(6);
        w_quot_sat  = (w_quotient[DIVIDEND_W-1:SCALE_W] != '0) ? SCALE_MAX
                                                               : w_quotient[SCALE_W-1:0];
        w_div_start = (r_state == S_DIV_SETUP) && w_need_div;
    end

    always_comb begin
        w_req.valid     = (r_state == S_CORRECT);
        w_req.axis      = r_axis;
        w_req.cal_valid = r_cal_valid;
        w_req.raw       = r_sample[r_axis];
        w_req.offset    = r_offset[r_axis];
        w_req.scale     = r_scale[r_axis];
    end

    mmc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    mmc_corrector u_corrector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (r_mode == MODE_FINISH && r_count >= r_min_count) begin
                    n_state = S_DIV_SETUP;
                end else begin
                    n_state = S_CORRECT;
                end
            end
            S_DIV_SETUP: begin
                if (w_need_div) begin
                    n_state = S_DIV_WAIT;
                end else if (r_axis == AXIS_Z) begin
                    n_state = S_CORRECT;
                end
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_axis == AXIS_Z) ? S_CORRECT : S_DIV_SETUP;
                end
            end
            S_CORRECT: begin
                if (r_axis == AXIS_Z) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (w_rsp.valid && w_rsp.axis == AXIS_Z) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min_count  <= MIN_COUNT_RESET;
            r_count      <= '0;
            r_collecting <= 1'b0;
            r_cal_valid  <= 1'b0;
            r_axis       <= AXIS_X;
            r_m_valid    <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_min[i]    <= {1'b0, {(SAMPLE_W-1){1'b1}}};
                r_max[i]    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
                r_offset[i] <= '0;
                r_scale[i]  <= SCALE_UNITY;
            end
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) r_min_count <= pwdata[COUNT_W-1:0];

            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_UPDATE: begin
                    r_axis <= AXIS_X;
                    case (r_mode)
                        MODE_START: begin
                            for (int i = 0; i < NUM_AXES; i++) begin
                                r_min[i] <= {1'b0, {(SAMPLE_W-1){1'b1}}};
                                r_max[i] <= {1'b1, {(SAMPLE_W-1){1'b0}}};
                            end
                            r_count      <= '0;
                            r_collecting <= 1'b1;
                            r_cal_valid  <= 1'b0;
                        end
                        MODE_FINISH: begin
                            r_collecting <= 1'b0;
                            if (r_count < r_min_count) begin
                                r_cal_valid <= 1'b0;
                            end else begin
                                r_cal_valid <= 1'b1;
                                for (int i = 0; i < NUM_AXES; i++) begin
                                    r_offset[i] <= OFFSET_W'(r_max[i]) + OFFSET_W'(r_min[i]);
                                end
                            end
                        end
                        MODE_SAMPLE: begin
                            if (r_collecting) begin
                                for (int i = 0; i < NUM_AXES; i++) begin
                                    if (r_sample[i] < r_min[i]) r_min[i] <= r_sample[i];
                                    if (r_sample[i] > r_max[i]) r_max[i] <= r_sample[i];
                                end
                                if (r_count != '1) r_count <= r_count + COUNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIV_SETUP: begin
                    if (!w_need_div) begin
                        r_scale[r_axis] <= (w_range_cur > RANGE_W'(2)) ? '0 : SCALE_UNITY;
                        r_axis <= (r_axis == AXIS_Z) ? AXIS_X : r_axis + t_axis'(1);
                    end
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_scale[r_axis] <= w_quot_sat;
                        r_axis <= (r_axis == AXIS_Z) ? AXIS_X : r_axis + t_axis'(1);
                    end
                end
                S_CORRECT: begin
                    r_axis <= (r_axis == AXIS_Z) ? AXIS_X : r_axis + t_axis'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_mode      <= s_axis_tuser;
            r_sample[0] <= s_axis_tdata[15:0];
            r_sample[1] <= s_axis_tdata[31:16];
            r_sample[2] <= s_axis_tdata[47:32];
        end
        if (r_state == S_UPDATE) begin
            if (r_mode == MODE_FINISH) begin
                r_status <= (r_count < r_min_count) ? STATUS_SHORT : STATUS_OK;
            end else begin
                r_status <= STATUS_NONE;
            end
        end
        if (w_rsp.valid) r_res[w_rsp.axis] <= w_rsp.value;
        if (w_out_load) begin
            r_m_data <= {r_res[2], r_res[1], r_res[0]};
            r_m_user <= {r_collecting, r_cal_valid, r_status};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign pready        = 1'b1;
    assign prdata        = paddr[2] ? '0 : APB_DATA_W'(r_min_count);

endmodule

// ----- src/mmc_checker.sv -----
// ----------------------------------------------------------------------------
// mmc_checker: port-level checks for the calibration block
// Watches the stream ports and flags broken sequencing, status codes or flags.
// ----------------------------------------------------------------------------
module mmc_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [71:0]  m_axis_tdata,
    input  logic [3:0]   m_axis_tuser
);
    import mmc_pkg::*;

    // The block works on one beat at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a beat is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("undefined finish status");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[3]))
        else $error("calibrated while still collecting");

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == STATUS_OK |-> m_axis_tuser[2])
        else $error("accepted finish without valid calibration");

endmodule

bind magnetometer_minmax_calibration mmc_checker u_mmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
